// File: design/sobm_pkg.sv
package sobm_pkg;

   localparam int CH_W     = 8;
   localparam int PIX_W    = 24;
   localparam int NUM_CH   = PIX_W / CH_W;
   localparam int NUM_TAPS = 9;
   localparam int EDGE_W   = 8;

   // gradient range is +/-1020, sum of squares at most 2080800
   localparam int GRAD_W = 11;
   localparam int SQ_W   = 21;
   localparam int ROOT_W = (SQ_W + 1) / 2;

   // gradient stage, square-sum stage, one stage per root bit
   localparam int LANE_STAGES = 2 + ROOT_W;
   // plus the merge / output register
   localparam int NUM_STAGES  = LANE_STAGES + 1;

   typedef logic [CH_W-1:0]   chan_type;
   typedef logic [PIX_W-1:0]  pix_type;
   typedef logic [ROOT_W-1:0] mag_type;
   typedef logic [EDGE_W-1:0] edge_type;

endpackage

// File: design/sobm_req_if.sv
interface sobm_req_if;
   import sobm_pkg::*;

   logic    valid;
   logic    ready;
   pix_type top_left;
   pix_type top_middle;
   pix_type top_right;
   pix_type middle_left;
   pix_type window_centre;
   pix_type middle_right;
   pix_type bottom_left;
   pix_type bottom_middle;
   pix_type bottom_right;

   modport source (
      output valid, top_left, top_middle, top_right, middle_left, window_centre,
             middle_right, bottom_left, bottom_middle, bottom_right,
      input  ready
   );
   modport sink (
      input  valid, top_left, top_middle, top_right, middle_left, window_centre,
             middle_right, bottom_left, bottom_middle, bottom_right,
      output ready
   );
endinterface

// File: design/sobm_rsp_if.sv
interface sobm_rsp_if;
   import sobm_pkg::*;

   logic     valid;
   logic     ready;
   edge_type edge_value;

   modport source (output valid, edge_value, input ready);
   modport sink (input valid, edge_value, output ready);
endinterface

// File: design/sobel_edge_magnitude_3x3_core.sv
// Sobel edge magnitude on 3x3 windows of 24-bit BGR pixels. One window is
// taken per request and gives one 8-bit edge value: the low byte of the
// largest of the three per-channel magnitudes floor(sqrt(gx^2 + gy^2)), so
// values above 255 wrap. Throughput is one request per clock unless the
// output stalls. Stages: gradient, square sum, the 11-stage bit-per-stage
// root pipeline and the merge register. A stage holds its data only while
// the stage after it is stalled, so bubbles collapse and requests keep
// entering while a result waits on the output until no bubble is left.
module sobel_edge_magnitude_3x3_core (
   input  logic       clock,
   input  logic       reset,
   sobm_req_if.sink   req_ch,
   sobm_rsp_if.source rsp_ch
);
   import sobm_pkg::*;

   // per-stage valid and advance
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] en;

   pix_type  win [NUM_TAPS];
   mag_type  mag [NUM_CH];
   mag_type  best;
   edge_type edge_in, edge_ff;

   // a stage moves when it is empty or its successor moves
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ch.ready;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         en[s] = !valid_ff[s] || en[s+1];
      end
   end

   always_comb begin
      for (int s = 0; s < NUM_STAGES; s++) begin
         if (en[s]) begin
            valid_in[s] = (s == 0) ? req_ch.valid : valid_ff[(s == 0) ? 0 : s - 1];
         end else begin
            valid_in[s] = valid_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ch.ready = en[0];

   // window in row order
   assign win[0] = req_ch.top_left;
   assign win[1] = req_ch.top_middle;
   assign win[2] = req_ch.top_right;
   assign win[3] = req_ch.middle_left;
   assign win[4] = req_ch.window_centre;
   assign win[5] = req_ch.middle_right;
   assign win[6] = req_ch.bottom_left;
   assign win[7] = req_ch.bottom_middle;
   assign win[8] = req_ch.bottom_right;

   // lane 0 blue, 1 green, 2 red
   for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
      chan_type pix [NUM_TAPS];

      for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
         assign pix[k] = win[k][c*CH_W +: CH_W];
      end

      sobm_lane u_lane (
         .clock (clock),
         .en    (en[LANE_STAGES-1:0]),
         .pix   (pix),
         .mag   (mag[c])
      );
   end

   // merge: max over full magnitudes, then keep the low byte
   always_comb begin
      best = mag[0];
      for (int c = 1; c < NUM_CH; c++) begin
         if (mag[c] > best) begin
            best = mag[c];
         end
      end
      edge_in = best[EDGE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[NUM_STAGES-1]) begin
         edge_ff <= edge_in;
      end
   end

   assign rsp_ch.valid      = valid_ff[NUM_STAGES-1];
   assign rsp_ch.edge_value = edge_ff;

endmodule

// File: design/sobm_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module sobm_isqrt (
   input  logic                          clock,
   input  logic [sobm_pkg::ROOT_W-1:0]   en,
   input  logic [sobm_pkg::SQ_W-1:0]     value,
   output sobm_pkg::mag_type             root
);
   import sobm_pkg::*;

   localparam int VAL_W = 2 * ROOT_W;

   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W:0]   rem_ff  [ROOT_W-1];
   logic [VAL_W-1:0]  val_ff  [ROOT_W-1];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic [ROOT_W:0]   rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [VAL_W-1:0]  val_prev;
      logic [ROOT_W+2:0] rem_sh;
      logic [ROOT_W+2:0] trial;
      logic [ROOT_W+2:0] diff;
      logic              take;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign val_prev  = VAL_W'(value);
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign val_prev  = val_ff[i-1];
      end

      // bring down the next digit pair, try (root << 2) | 1
      assign rem_sh = {rem_prev, val_prev[VAL_W-1 -: 2]};
      assign trial  = {1'b0, root_prev, 2'b01};
      assign take   = (rem_sh >= trial);
      assign diff   = rem_sh - trial;

      always_ff @(posedge clock) begin
         if (en[i]) begin
            root_ff[i] <= {root_prev[ROOT_W-2:0], take};
         end
      end

      if (i < ROOT_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en[i]) begin
               rem_ff[i] <= take ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
               val_ff[i] <= {val_prev[VAL_W-3:0], 2'b00};
            end
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

// File: design/sobm_lane.sv
// One color channel: Sobel gradients, sum of squares, root.
module sobm_lane (
   input  logic                               clock,
   input  logic [sobm_pkg::LANE_STAGES-1:0]   en,
   input  sobm_pkg::chan_type                 pix [sobm_pkg::NUM_TAPS],
   output sobm_pkg::mag_type                  mag
);
   import sobm_pkg::*;

   logic signed [GRAD_W-1:0]   p [NUM_TAPS];
   logic signed [GRAD_W-1:0]   gx_in, gy_in;
   logic signed [GRAD_W-1:0]   gx_ff, gy_ff;
   logic signed [2*GRAD_W-1:0] sqx, sqy;
   logic [SQ_W-1:0]            sum_in, sum_ff;

   always_comb begin
      for (int k = 0; k < NUM_TAPS; k++) begin
         p[k] = $signed({{(GRAD_W-CH_W){1'b0}}, pix[k]});
      end
   end

   // taps in row order; x kernel {1,0,-1} {2,0,-2} {1,0,-1},
   // y kernel {1,2,1} {0,0,0} {-1,-2,-1}
   assign gx_in = p[0] - p[2] + (p[3] <<< 1) - (p[5] <<< 1) + p[6] - p[8];
   assign gy_in = p[0] + (p[1] <<< 1) + p[2] - p[6] - (p[7] <<< 1) - p[8];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
   end

   assign sqx    = gx_ff * gx_ff;
   assign sqy    = gy_ff * gy_ff;
   assign sum_in = SQ_W'($unsigned(sqx) + $unsigned(sqy));

   always_ff @(posedge clock) begin
      if (en[1]) begin
         sum_ff <= sum_in;
      end
   end

   sobm_isqrt u_isqrt (
      .clock (clock),
      .en    (en[LANE_STAGES-1:2]),
      .value (sum_ff),
      .root  (mag)
   );

endmodule
